FILE: design/square_matrix_multiply_defines.svh
// Assertion macros shared by the square matrix multiply design.
`ifndef SQUARE_MATRIX_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/smm_pkg.sv
// Shared types and constants for the square matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 16;
    localparam int SIZE_W  = 7;
    localparam int OUT_W   = 38;

    // Controller to datapath
    typedef struct packed {
        logic write_a;
        logic write_b;
        logic start;
        logic issue;
        logic load_out;
    } smm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_range;
        logic last_k;
        logic pipe_busy;
    } smm_status_t;

endpackage

`default_nettype wire

FILE: design/square_matrix_multiply.sv
// Operation: a write is stored while idle; a read of an element of C runs one MAC per
// cycle over the inner dimension n, n being the size in use, each term passing memory
// read, multiply and accumulate registers, and the sum is then loaded into the output register.
// Throughput: one write per cycle while idle; one read at a time, set by the single MAC.
// Reset: synchronous, active low; clears control state and sets size_in_use to 64.
// Matrix memories are not cleared: an element must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "square_matrix_multiply_defines.svh"

module square_matrix_multiply #(
    parameter int MAX_SIZE     = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // row[5:0], column[11:6], value[27:12], zero pad
    input  wire logic [1:0]  s_tuser,  // operation[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // product_element[37:0], zero pad
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_SIZE_IN_USE = 1'b0;

    logic [smm_pkg::SIZE_W-1:0]        size_reg;
    logic [smm_pkg::SIZE_W-1:0]        size_next;
    logic                              cfg_write;
    smm_pkg::smm_cmd_t                 cmd;
    smm_pkg::smm_status_t              status;
    logic signed [smm_pkg::OUT_W-1:0]  product_element;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        size_next = size_reg;
        if (cfg_write && (paddr[2] == REG_SIZE_IN_USE)) begin
            size_next = pwdata[smm_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= smm_pkg::SIZE_W'(64);
        end else begin
            size_reg <= size_next;
        end
    end

    assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_reg) : 32'd0;

    smm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smm_dp #(
        .MAX_SIZE     (MAX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .size_in_use     (size_reg),
        .in_row          (s_tdata[5:0]),
        .in_column       (s_tdata[11:6]),
        .in_value        (s_tdata[27:12]),
        .cmd             (cmd),
        .status          (status),
        .product_element (product_element)
    );

    assign m_tdata = {2'b00, product_element};

    `SMM_ASSERT_NEXT(a_issue_fills_pipe, cmd.issue, status.pipe_busy, "issued read left no data in the MAC pipeline")
    `SMM_ASSERT_SAME(a_load_after_drain, cmd.load_out, !status.pipe_busy, "result loaded while products still in flight")
    `SMM_ASSERT_SAME(a_start_when_empty, cmd.start, !status.pipe_busy, "read started over an unfinished dot product")
    `SMM_ASSERT_SAME(a_valid_from_load, $rose(m_tvalid), $past(cmd.load_out), "result valid without a load")

endmodule

`default_nettype wire

FILE: design/smm_ctrl.sv
// Controller state machine sequencing writes, dot-product runs and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module smm_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [smm_pkg::OP_W-1:0] op,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire smm_pkg::smm_status_t     status,
    output smm_pkg::smm_cmd_t             cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.write_a  = accept && (op == smm_pkg::OP_WRITE_A);
        cmd.write_b  = accept && (op == smm_pkg::OP_WRITE_B);
        cmd.start    = accept && (op == smm_pkg::OP_READ);
        cmd.issue    = (state_reg == ST_RUN);
        cmd.load_out = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    // out-of-range reads skip straight to a zero result
                    state_next = status.in_range ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN: begin
                if (status.last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (cmd.load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/smm_dp.sv
// Datapath: matrix memories, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module smm_dp #(
    parameter int MAX_SIZE     = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [smm_pkg::SIZE_W-1:0]         size_in_use,
    input  wire logic [smm_pkg::INDEX_W-1:0]        in_row,
    input  wire logic [smm_pkg::INDEX_W-1:0]        in_column,
    input  wire logic signed [smm_pkg::VALUE_W-1:0] in_value,
    input  wire smm_pkg::smm_cmd_t                  cmd,
    output smm_pkg::smm_status_t                    status,
    output logic signed [smm_pkg::OUT_W-1:0]        product_element
);

    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int SUM_W  = ((PROD_W > smm_pkg::OUT_W) ? PROD_W : smm_pkg::OUT_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        (SUM_W'(1) <<< (smm_pkg::OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [ELEMENT_BITS-1:0] mem_a [DEPTH];
    logic signed [ELEMENT_BITS-1:0] mem_b [DEPTH];

    logic [CNT_W-1:0]               eff_size;
    logic                           wr_in_store;
    logic [ADDR_W-1:0]              wr_addr;
    logic signed [ELEMENT_BITS-1:0] wr_elem;

    logic [IDX_W-1:0]               row_reg;
    logic [IDX_W-1:0]               col_reg;
    logic [IDX_W-1:0]               k_reg;
    logic [IDX_W-1:0]               k_next;

    logic signed [ELEMENT_BITS-1:0] a_rd_reg;
    logic signed [ELEMENT_BITS-1:0] b_rd_reg;
    logic                           rd_vld_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           prod_vld_reg;
    logic signed [smm_pkg::OUT_W-1:0] acc_reg;
    logic signed [smm_pkg::OUT_W-1:0] acc_next;
    logic signed [SUM_W-1:0]        sum;
    logic signed [smm_pkg::OUT_W-1:0] out_reg;

    // Size zero acts as one, anything above the storage acts as the storage size
    always_comb begin
        if (size_in_use == '0) begin
            eff_size = CNT_W'(1);
        end else if (32'(size_in_use) > 32'(MAX_SIZE)) begin
            eff_size = CNT_W'(MAX_SIZE);
        end else begin
            eff_size = CNT_W'(size_in_use);
        end
    end

    always_comb begin
        status.in_range  = (32'(in_row) < 32'(eff_size)) && (32'(in_column) < 32'(eff_size));
        status.last_k    = (CNT_W'(k_reg) == (eff_size - CNT_W'(1)));
        status.pipe_busy = rd_vld_reg || prod_vld_reg;
    end

    assign wr_in_store = (32'(in_row) < 32'(MAX_SIZE)) && (32'(in_column) < 32'(MAX_SIZE));
    assign wr_addr     = {IDX_W'(in_row), IDX_W'(in_column)};
    assign wr_elem     = ELEMENT_BITS'(in_value);

    // Left matrix: row-major, walked along the row
    always_ff @(posedge aclk) begin
        if (cmd.write_a && wr_in_store) begin
            mem_a[wr_addr] <= wr_elem;
        end
        if (cmd.issue) begin
            a_rd_reg <= mem_a[{row_reg, k_reg}];
        end
    end

    // Right matrix: row-major, walked down the column
    always_ff @(posedge aclk) begin
        if (cmd.write_b && wr_in_store) begin
            mem_b[wr_addr] <= wr_elem;
        end
        if (cmd.issue) begin
            b_rd_reg <= mem_b[{k_reg, col_reg}];
        end
    end

    always_comb begin
        if (cmd.start) begin
            k_next = '0;
        end else if (cmd.issue) begin
            k_next = k_reg + IDX_W'(1);
        end else begin
            k_next = k_reg;
        end
    end

    assign sum = SUM_W'(acc_reg) + SUM_W'(prod_reg);

    // Saturate the running sum after each term
    always_comb begin
        if (cmd.start) begin
            acc_next = '0;
        end else if (!prod_vld_reg) begin
            acc_next = acc_reg;
        end else if (sum > SAT_HI) begin
            acc_next = SAT_HI[smm_pkg::OUT_W-1:0];
        end else if (sum < SAT_LO) begin
            acc_next = SAT_LO[smm_pkg::OUT_W-1:0];
        end else begin
            acc_next = sum[smm_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            row_reg <= IDX_W'(in_row);
            col_reg <= IDX_W'(in_column);
        end
        k_reg    <= k_next;
        prod_reg <= a_rd_reg * b_rd_reg;
        acc_reg  <= acc_next;
        if (cmd.load_out) begin
            out_reg <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    assign product_element = out_reg;

endmodule

`default_nettype wire

FILE: tb/sv/square_matrix_multiply_test.sv
// Self-checking stream testbench for the square matrix multiply block.
`timescale 1ns / 1ps

module square_matrix_multiply_test;

    localparam int          MATRIX_DIM    = 64;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [2:0]  SIZE_REG_ADDR = 3'd0;
    // leave margin after the longest read before touching the register
    localparam int          SETTLE_CYCLES = 100;
    // ~1300 transactions, a third reads, under heavy stalls, x8
    localparam int          CYCLE_LIMIT   = 600000;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [smm_pkg::OP_W-1:0]           operation;
        logic [smm_pkg::INDEX_W-1:0]        row;
        logic [smm_pkg::INDEX_W-1:0]        column;
        logic signed [smm_pkg::VALUE_W-1:0] value;
    } matrix_op_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // row[5:0], column[11:6], value[27:12], zero pad
    logic [1:0]  s_tuser  = '0;  // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // product_element[37:0], zero pad
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    square_matrix_multiply u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic signed [smm_pkg::VALUE_W-1:0] left_elems  [0:MATRIX_DIM*MATRIX_DIM-1];
    logic signed [smm_pkg::VALUE_W-1:0] right_elems [0:MATRIX_DIM*MATRIX_DIM-1];
    logic [smm_pkg::SIZE_W-1:0]         size_reg = 7'd64;

    // generator's view of which elements hold data
    bit a_known [0:MATRIX_DIM-1][0:MATRIX_DIM-1];
    bit b_known [0:MATRIX_DIM-1][0:MATRIX_DIM-1];

    matrix_op_t                 pending_items[$];
    logic [smm_pkg::OUT_W-1:0]  expected_products[$];
    matrix_op_t                 held_item;
    bit                         item_held = 1'b0;
    logic [smm_pkg::OUT_W-1:0]  oldest_product;
    int                         total_items = 0;
    int                         failures = 0;
    int                         cycle_count = 0;
    int                         sender_idle_pct = 0;
    int                         receiver_stall_pct = 0;

    function automatic int effective_size(input logic [smm_pkg::SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MATRIX_DIM)
            return MATRIX_DIM;
        return int'(s);
    endfunction

    function automatic logic [smm_pkg::OUT_W-1:0] dot_product(
        input logic [smm_pkg::INDEX_W-1:0] r,
        input logic [smm_pkg::INDEX_W-1:0] c);
        longint acc;
        longint hi;
        longint lo;
        int     n;
        int     k;
        hi  = (longint'(1) <<< (smm_pkg::OUT_W - 1)) - 1;
        lo  = -hi - 1;
        n   = effective_size(size_reg);
        acc = 0;
        if (r < n && c < n) begin
            for (k = 0; k < n; k++) begin
                acc += longint'(left_elems[r*MATRIX_DIM+k]) *
                       longint'(right_elems[k*MATRIX_DIM+c]);
                if (acc > hi)
                    acc = hi;
                if (acc < lo)
                    acc = lo;
            end
        end
        return acc[smm_pkg::OUT_W-1:0];
    endfunction

    task automatic apply_operation(input matrix_op_t t);
        case (t.operation)
            smm_pkg::OP_WRITE_A: left_elems[t.row*MATRIX_DIM+t.column] = t.value;
            smm_pkg::OP_WRITE_B: right_elems[t.row*MATRIX_DIM+t.column] = t.value;
            smm_pkg::OP_READ:    expected_products.push_back(dot_product(t.row, t.column));
            default: ;  // unused code: no effect
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_operation(held_item);
                item_held = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    held_item = pending_items.pop_front();
                    item_held = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, held_item.value, held_item.column, held_item.row};
                    s_tuser  <= held_item.operation;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_products.size() == 0) begin
                    $error("product_element: none expected, actual %0d",
                           $signed(m_tdata[smm_pkg::OUT_W-1:0]));
                    failures++;
                end else begin
                    oldest_product = expected_products.pop_front();
                    if (m_tdata[smm_pkg::OUT_W-1:0] !== oldest_product) begin
                        $error("product_element: expected %0d, actual %0d",
                               $signed(oldest_product),
                               $signed(m_tdata[smm_pkg::OUT_W-1:0]));
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("square_matrix_multiply regression: fail");
            $finish;
        end
    end

    function automatic logic signed [smm_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return smm_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic [smm_pkg::OP_W-1:0] op, input int r,
                             input int c,
                             input logic signed [smm_pkg::VALUE_W-1:0] v);
        matrix_op_t t;
        t.operation = op;
        t.row       = smm_pkg::INDEX_W'(r);
        t.column    = smm_pkg::INDEX_W'(c);
        t.value     = v;
        pending_items.push_back(t);
        if (op == smm_pkg::OP_WRITE_A)
            a_known[r][c] = 1'b1;
        if (op == smm_pkg::OP_WRITE_B)
            b_known[r][c] = 1'b1;
        if (op != OP_UNUSED)
            total_items++;
    endtask

    // a read in range needs row r of A and column c of B written up to the size
    function automatic bit read_ready(input int r, input int c, input int n);
        int k;
        if (r >= n || c >= n)
            return 1'b1;
        for (k = 0; k < n; k++)
            if (!a_known[r][k] || !b_known[k][c])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic gen_items(input int count);
        int target;
        int n;
        int pick;
        int r;
        int c;
        int k;
        int stop;
        int tries;
        target = total_items + count;
        n      = effective_size(size_reg);
        while (total_items < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // row of A and column of B, then the read; a few are cut short
                r    = $urandom_range(n - 1);
                c    = $urandom_range(n - 1);
                stop = (pick < 48) ? n : $urandom_range(n - 1);
                for (k = 0; k < stop; k++) begin
                    push_item(smm_pkg::OP_WRITE_A, r, k, rand_value());
                    push_item(smm_pkg::OP_WRITE_B, k, c, rand_value());
                end
                if (stop == n)
                    push_item(smm_pkg::OP_READ, r, c, rand_value());
            end else if (pick < 80) begin
                for (tries = 0; tries < 16; tries++) begin
                    r = $urandom_range(n - 1);
                    c = $urandom_range(n - 1);
                    if (read_ready(r, c, n)) begin
                        push_item(smm_pkg::OP_READ, r, c, rand_value());
                        break;
                    end
                end
            end else if (pick < 88) begin
                if (n < MATRIX_DIM) begin
                    r = $urandom_range(MATRIX_DIM - 1, n);
                    c = $urandom_range(MATRIX_DIM - 1);
                    if ($urandom_range(1))
                        push_item(smm_pkg::OP_READ, r, c, rand_value());
                    else
                        push_item(smm_pkg::OP_READ, c, r, rand_value());
                end
            end else if (pick < 97) begin
                push_item($urandom_range(1) ? smm_pkg::OP_WRITE_B : smm_pkg::OP_WRITE_A,
                          $urandom_range(MATRIX_DIM - 1), $urandom_range(MATRIX_DIM - 1),
                          rand_value());
            end else begin
                push_item(OP_UNUSED, $urandom_range(MATRIX_DIM - 1),
                          $urandom_range(MATRIX_DIM - 1), rand_value());
            end
        end
    endtask

    task automatic wait_results();
        while (pending_items.size() != 0 || item_held || expected_products.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_size(input logic [smm_pkg::SIZE_W-1:0] s);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_REG_ADDR;
        pwdata  <= {25'($urandom), s};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        size_reg = s;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
            IDLE_BOTH:     begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_phase(input logic [smm_pkg::SIZE_W-1:0] s, input idle_mode_t mode,
                             input int count, input bit pause_midway);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_size(s);
        set_mode(mode);
        if (pause_midway) begin
            // hold the sender until every product has come back
            gen_items(count / 2);
            wait_results();
            gen_items(count - count / 2);
        end else begin
            gen_items(count);
        end
    endtask

    initial begin
        idle_mode_t mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: extreme values at size two
        write_size(7'd2);
        set_mode(IDLE_NONE);
        push_item(smm_pkg::OP_WRITE_A, 0, 0, 16'sh7FFF);
        push_item(smm_pkg::OP_WRITE_A, 0, 1, 16'sh8000);
        push_item(smm_pkg::OP_WRITE_B, 0, 0, 16'sh7FFF);
        push_item(smm_pkg::OP_WRITE_B, 1, 0, 16'sh8000);
        push_item(smm_pkg::OP_WRITE_A, 1, 0, 16'sh8000);
        push_item(smm_pkg::OP_WRITE_A, 1, 1, 16'sh8000);
        push_item(smm_pkg::OP_WRITE_B, 0, 1, 16'sh8000);
        push_item(smm_pkg::OP_WRITE_B, 1, 1, -16'sd1);
        push_item(smm_pkg::OP_READ, 0, 0, 16'sh0000);
        push_item(smm_pkg::OP_READ, 0, 1, 16'shFFFF);
        push_item(smm_pkg::OP_READ, 1, 0, 16'sh5555);
        push_item(smm_pkg::OP_READ, 1, 1, 16'shAAAA);
        // outside the size in use: zero
        push_item(smm_pkg::OP_READ, 1, 2, rand_value());
        push_item(smm_pkg::OP_READ, 63, 0, rand_value());
        // stored although beyond the size in use
        push_item(smm_pkg::OP_WRITE_A, 63, 63, 16'sh1234);
        push_item(smm_pkg::OP_WRITE_B, 63, 63, -16'sd1);
        push_item(OP_UNUSED, 0, 0, 16'sh7FFF);
        push_item(smm_pkg::OP_WRITE_A, 0, 5, 16'sh5A5A);
        push_item(smm_pkg::OP_READ, 0, 0, rand_value());

        run_phase(7'd4,   IDLE_NONE,     150, 1'b0);
        run_phase(7'd1,   IDLE_SENDER,   100, 1'b1);
        run_phase(7'd0,   IDLE_RECEIVER,  80, 1'b0);
        run_phase(7'd8,   IDLE_BOTH,     150, 1'b0);
        run_phase(7'd64,  IDLE_NONE,     260, 1'b0);
        run_phase(7'd127, IDLE_RECEIVER, 140, 1'b0);
        mode = IDLE_NONE;
        while (total_items < 1100) begin
            run_phase(smm_pkg::SIZE_W'($urandom_range(12, 2)), mode, 80, 1'b0);
            mode = (mode == IDLE_BOTH) ? IDLE_NONE : idle_mode_t'(int'(mode) + 1);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_products.size() != 0) begin
            $error("product_element: %0d expected but never returned",
                   expected_products.size());
            failures++;
        end
        if (failures == 0) begin
            $display("square_matrix_multiply regression: pass");
        end else begin
            $display("square_matrix_multiply regression: fail");
        end
        $finish;
    end

endmodule
